@@ hw/rtl/pv_surplus_analyzer_macros.svh @@
// Assertion macros for the PV surplus analyzer.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef PV_SURPLUS_ANALYZER_MACROS_SVH
`define PV_SURPLUS_ANALYZER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define PVSA_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pvsa: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define PVSA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pvsa: next-cycle check failed");

`endif

@@ hw/rtl/pvsa_pkg.sv @@
// Package for the PV surplus analyzer: widths, constants, register codes, types.
// No dependencies; used by pvsa_div and pv_surplus_analyzer.
`default_nettype none

package pvsa_pkg;

    // History ring: depth is a power of two so the means are plain shifts.
    localparam int HIST_W     = 4;
    localparam int HIST_DEPTH = 1 << HIST_W;
    localparam int SUM_W      = 16 + HIST_W;

    // Trend looks at this many consecutive PV changes.
    localparam int TREND_LEN  = 4;

    localparam int PV_TOL_KNEE = 2000;
    localparam int PV_TOL_UNIT = 1000;
    localparam int DIST_SCALE  = 10;
    localparam int DIST_MAX    = 65535;
    localparam int TOL_W       = 7;

    // Serial divider widths: dividend up to 10 * 65534, divisor up to 16 bits.
    localparam int DIV_N_W   = 20;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HI = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic [15:0] pv;
        logic [15:0] abs_chg;
    } ring_entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/pvsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pvsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/pvsa_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on pvsa_pkg.
`default_nettype none

module pvsa_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [pvsa_pkg::DIV_N_W-1:0]   dividend,
    input  wire logic [pvsa_pkg::DIV_D_W-1:0]   divisor,
    output pvsa_pkg::div_stat_t                 stat,
    output logic      [pvsa_pkg::DIV_N_W-1:0]   quotient
);

    import pvsa_pkg::*;

    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W+1:0]   trial;

    // Bring down the next dividend bit and try to subtract.
    assign shifted = {rem_reg, quo_reg[DIV_N_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_D_W+1])
            begin
                rem_next = trial[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pv_surplus_analyzer.sv @@
// PV surplus analyzer top level: sample handshake, history ring, result register.
// Depends on pvsa_pkg, pvsa_ram, pvsa_div and pv_surplus_analyzer_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one power sample per request:
//   grid, battery, site load and the two inverter outputs. Output channel
//   (out_valid/out_ready) returns exactly one result per sample, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   index 0 noise threshold, 1 keep band low, 2 keep band high, others ignored.
//   Write config only while no sample is in flight.
// Sequence:
//   Each accepted sample passes twice through the shared bit-serial divider
//   (PV / 1000, then the distortion quotient, skipped when the mean PV is
//   zero), between the steps CALC1, CALC2, MUL, GREEDY, MODEST and OUT.
//   One sample is in flight at a time: a new request is accepted only once
//   the sequencer is back in idle, after the last result went to the output.
// Reset:
//   Clears the history ring (through per-entry valid bits), the running sums,
//   the last net load and the ring index, and loads the register defaults.
// Stall:
//   A finished result waits in the output register; the next sample is
//   already accepted and worked on, and holds in its last step until the
//   output register frees up.
`default_nettype none
`include "pv_surplus_analyzer_macros.svh"

module pv_surplus_analyzer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pvsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pvsa_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Sample requests
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [15:0]                 grid_power,
    input  wire logic signed [15:0]                 battery_power,
    input  wire logic signed [15:0]                 site_load,
    input  wire logic        [14:0]                 pv_main,
    input  wire logic        [14:0]                 pv_second,
    // Results
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic             [15:0]                 pv_total,
    output logic signed      [16:0]                 pv_change,
    output logic signed      [16:0]                 net_load,
    output logic signed      [17:0]                 load_change,
    output logic signed      [17:0]                 balance_sum,
    output logic             [14:0]                 waste_power,
    output logic             [15:0]                 distortion,
    output logic signed      [1:0]                  trend,
    output logic signed      [17:0]                 surplus,
    output logic signed      [19:0]                 greedy_power,
    output logic signed      [19:0]                 modest_power
);

    import pvsa_pkg::*;

    // Sequencer codes
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CALC1     = 4'd1;
    localparam logic [3:0] S_CALC2     = 4'd2;
    localparam logic [3:0] S_TOL       = 4'd3;
    localparam logic [3:0] S_TOL_WAIT  = 4'd4;
    localparam logic [3:0] S_DIST      = 4'd5;
    localparam logic [3:0] S_DIST_WAIT = 4'd6;
    localparam logic [3:0] S_MUL       = 4'd7;
    localparam logic [3:0] S_GREEDY    = 4'd8;
    localparam logic [3:0] S_MODEST    = 4'd9;
    localparam logic [3:0] S_OUT       = 4'd10;

    localparam int KB_W = 22;  // keep band edge times tolerance
    localparam int GD_W = 23;  // surplus minus keep band edge

    // Saturate to the 20 bit result range.
    function automatic logic signed [19:0] sat20(input logic signed [GD_W-1:0] v);
        logic signed [GD_W-1:0] hi;
        logic signed [GD_W-1:0] lo;
        hi = GD_W'(524287);
        lo = -GD_W'(524288);
        if (v > hi)
        begin
            sat20 = 20'sd524287;
        end
        else if (v < lo)
        begin
            sat20 = -20'sd524288;
        end
        else
        begin
            sat20 = v[19:0];
        end
    endfunction

    // ---------------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------------
    logic [3:0]              state_reg, state_next;
    logic [HIST_W-1:0]       ring_idx_reg, ring_idx_next;
    logic [HIST_DEPTH-1:0]   ring_vld_reg, ring_vld_next;
    logic [SUM_W-1:0]        pv_sum_reg, pv_sum_next;
    logic [SUM_W-1:0]        chg_sum_reg, chg_sum_next;
    logic [15:0]             last_pv_reg, last_pv_next;
    logic signed [16:0]      last_net_reg, last_net_next;
    logic [TREND_LEN-2:0]    neg_hist_reg, neg_hist_next;
    logic [TREND_LEN-2:0]    pos_hist_reg, pos_hist_next;
    logic                    out_valid_reg, out_valid_next;

    logic [9:0]              noise_reg, noise_next;
    logic signed [13:0]      band_lo_reg, band_lo_next;
    logic signed [13:0]      band_hi_reg, band_hi_next;

    // ---------------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------------
    logic signed [15:0]      grid_reg, batt_reg, load_reg;
    logic [14:0]             pvm_reg, pvs_reg;

    logic [15:0]             w_pv_reg, w_pv_next;
    logic signed [16:0]      w_dpv_reg, w_dpv_next;
    logic signed [16:0]      w_net_reg, w_net_next;
    logic signed [17:0]      w_dload_reg, w_dload_next;
    logic signed [17:0]      w_sum_reg, w_sum_next;
    logic signed [17:0]      w_surplus_reg, w_surplus_next;
    logic [14:0]             w_waste_reg, w_waste_next;
    logic [15:0]             w_abs_batt_reg, w_abs_batt_next;
    logic signed [1:0]       w_trend_reg, w_trend_next;
    logic [TOL_W-1:0]        w_tol_reg, w_tol_next;
    logic [15:0]             w_dist_reg, w_dist_next;
    logic signed [KB_W-1:0]  w_kf_reg, w_kf_next;
    logic signed [KB_W-1:0]  w_kt_reg, w_kt_next;
    logic signed [19:0]      w_greedy_reg, w_greedy_next;
    logic signed [19:0]      w_modest_reg, w_modest_next;

    logic [15:0]             o_pv_reg;
    logic signed [16:0]      o_dpv_reg, o_net_reg;
    logic signed [17:0]      o_dload_reg, o_sum_reg, o_surplus_reg;
    logic [14:0]             o_waste_reg;
    logic [15:0]             o_dist_reg;
    logic signed [1:0]       o_trend_reg;
    logic signed [19:0]      o_greedy_reg, o_modest_reg;

    // ---------------------------------------------------------------------
    // Ring memory and divider
    // ---------------------------------------------------------------------
    ring_entry_t             ram_wdata, ram_rdata, old_entry;
    logic                    ram_we;

    logic                    div_start;
    logic [DIV_N_W-1:0]      div_dividend;
    logic [DIV_D_W-1:0]      div_divisor;
    div_stat_t               div_stat;
    logic [DIV_N_W-1:0]      div_quotient;

    pvsa_ram #(
        .WIDTH ($bits(ring_entry_t)),
        .DEPTH (HIST_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_idx_reg),
        .wdata (ram_wdata),
        .raddr (ring_idx_reg),
        .rdata (ram_rdata)
    );

    pvsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // ---------------------------------------------------------------------
    // First step: sums and differences straight from the sample
    // ---------------------------------------------------------------------
    logic [15:0]             c1_pv;
    logic signed [16:0]      c1_grid17, c1_batt17, c1_noise17;
    logic signed [16:0]      c1_abs_grid;

    assign c1_pv       = {1'b0, pvm_reg} + {1'b0, pvs_reg};
    assign c1_grid17   = {grid_reg[15], grid_reg};
    assign c1_batt17   = {batt_reg[15], batt_reg};
    assign c1_noise17  = $signed({7'b0, noise_reg});
    assign c1_abs_grid = -c1_grid17;

    // ---------------------------------------------------------------------
    // Second step: ring update, running sums, load change, trend
    // ---------------------------------------------------------------------
    logic signed [17:0]      c2_dload;
    logic [17:0]             c2_dload_mag;
    logic [15:0]             c2_abs_dpv;
    logic                    c2_neg, c2_pos;
    logic [15:0]             avg_pv, avg_chg;

    assign old_entry    = ring_vld_reg[ring_idx_reg] ? ram_rdata : '0;
    assign c2_dload     = {w_net_reg[16], w_net_reg} - {last_net_reg[16], last_net_reg};
    assign c2_dload_mag = c2_dload[17] ? 18'(-c2_dload) : 18'(c2_dload);
    assign c2_abs_dpv   = w_dpv_reg[16] ? 16'(-w_dpv_reg) : w_dpv_reg[15:0];
    assign c2_neg       = w_dpv_reg[16];
    assign c2_pos       = !w_dpv_reg[16] && (w_dpv_reg != '0);

    assign ram_wdata.pv      = w_pv_reg;
    assign ram_wdata.abs_chg = c2_abs_dpv;
    assign ram_we            = (state_reg == S_CALC2);

    // Means over the ring are shifts of the running sums.
    assign avg_pv  = pv_sum_reg[SUM_W-1:HIST_W];
    assign avg_chg = chg_sum_reg[SUM_W-1:HIST_W];

    // ---------------------------------------------------------------------
    // Band and greedy arithmetic
    // ---------------------------------------------------------------------
    logic signed [GD_W-1:0]  g_surplus, g_kt, g_kf, g_diff, m_diff;

    assign g_surplus = GD_W'(w_surplus_reg);
    assign g_kt      = GD_W'(w_kt_reg);
    assign g_kf      = GD_W'(w_kf_reg);
    assign m_diff    = GD_W'(w_greedy_reg) - $signed({7'b0, w_abs_batt_reg});

    always_comb
    begin
        if (g_surplus > g_kt)
        begin
            g_diff = g_surplus - g_kt;
        end
        else if (g_surplus < g_kf)
        begin
            g_diff = g_surplus - g_kf;
        end
        else
        begin
            g_diff = '0;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    logic out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        ring_idx_next   = ring_idx_reg;
        ring_vld_next   = ring_vld_reg;
        pv_sum_next     = pv_sum_reg;
        chg_sum_next    = chg_sum_reg;
        last_pv_next    = last_pv_reg;
        last_net_next   = last_net_reg;
        neg_hist_next   = neg_hist_reg;
        pos_hist_next   = pos_hist_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        w_pv_next       = w_pv_reg;
        w_dpv_next      = w_dpv_reg;
        w_net_next      = w_net_reg;
        w_dload_next    = w_dload_reg;
        w_sum_next      = w_sum_reg;
        w_surplus_next  = w_surplus_reg;
        w_waste_next    = w_waste_reg;
        w_abs_batt_next = w_abs_batt_reg;
        w_trend_next    = w_trend_reg;
        w_tol_next      = w_tol_reg;
        w_dist_next     = w_dist_reg;
        w_kf_next       = w_kf_reg;
        w_kt_next       = w_kt_reg;
        w_greedy_next   = w_greedy_reg;
        w_modest_next   = w_modest_reg;

        div_start       = 1'b0;
        div_dividend    = {4'b0, w_pv_reg};
        div_divisor     = DIV_D_W'(PV_TOL_UNIT);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CALC1;
                end
            end

            S_CALC1:
            begin
                w_pv_next      = c1_pv;
                w_dpv_next     = $signed({1'b0, c1_pv}) - $signed({1'b0, last_pv_reg});
                w_net_next     = {load_reg[15], load_reg} - $signed({2'b0, pvs_reg});
                w_sum_next     = 18'(grid_reg) + 18'(batt_reg) + 18'(load_reg)
                               + $signed({3'b0, pvm_reg});
                w_surplus_next = -(18'(grid_reg) + 18'(batt_reg));
                w_abs_batt_next = batt_reg[15] ? 16'(-c1_batt17) : batt_reg;
                w_waste_next   = '0;
                // Battery discharging straight into the grid: both flows above noise.
                if ((c1_batt17 > c1_noise17) && (c1_grid17 < -c1_noise17))
                begin
                    w_waste_next = (c1_abs_grid < c1_batt17) ? c1_abs_grid[14:0]
                                                             : batt_reg[14:0];
                end
                state_next = S_CALC2;
            end

            S_CALC2:
            begin
                w_dload_next = (c2_dload_mag < {8'b0, noise_reg}) ? '0 : c2_dload;
                // Swap the overwritten entry out of the running sums.
                pv_sum_next  = pv_sum_reg - SUM_W'(old_entry.pv) + SUM_W'(w_pv_reg);
                chg_sum_next = chg_sum_reg - SUM_W'(old_entry.abs_chg)
                             + SUM_W'(c2_abs_dpv);
                ring_vld_next[ring_idx_reg] = 1'b1;
                ring_idx_next = ring_idx_reg + 1'b1;
                last_pv_next  = w_pv_reg;
                last_net_next = w_net_reg;
                if (c2_neg && (&neg_hist_reg))
                begin
                    w_trend_next = -2'sd1;
                end
                else if (c2_pos && (&pos_hist_reg))
                begin
                    w_trend_next = 2'sd1;
                end
                else
                begin
                    w_trend_next = 2'sd0;
                end
                neg_hist_next = {neg_hist_reg[TREND_LEN-3:0], c2_neg};
                pos_hist_next = {pos_hist_reg[TREND_LEN-3:0], c2_pos};
                state_next    = S_TOL;
            end

            S_TOL:
            begin
                div_start  = 1'b1;
                state_next = S_TOL_WAIT;
            end

            S_TOL_WAIT:
            begin
                if (div_stat.done)
                begin
                    w_tol_next = (w_pv_reg > 16'(PV_TOL_KNEE)) ? div_quotient[TOL_W-1:0]
                                                               : TOL_W'(1);
                    state_next = S_DIST;
                end
            end

            S_DIST:
            begin
                if (avg_pv == '0)
                begin
                    w_dist_next = '0;
                    state_next  = S_MUL;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_N_W'(avg_chg) * DIV_N_W'(DIST_SCALE);
                    div_divisor  = avg_pv;
                    state_next   = S_DIST_WAIT;
                end
            end

            S_DIST_WAIT:
            begin
                if (div_stat.done)
                begin
                    w_dist_next = (div_quotient > DIV_N_W'(DIST_MAX)) ? 16'(DIST_MAX)
                                                                      : div_quotient[15:0];
                    state_next  = S_MUL;
                end
            end

            S_MUL:
            begin
                w_kf_next  = $signed({{(KB_W-14){band_lo_reg[13]}}, band_lo_reg})
                           * $signed({{(KB_W-TOL_W){1'b0}}, w_tol_reg});
                w_kt_next  = $signed({{(KB_W-14){band_hi_reg[13]}}, band_hi_reg})
                           * $signed({{(KB_W-TOL_W){1'b0}}, w_tol_reg});
                state_next = S_GREEDY;
            end

            S_GREEDY:
            begin
                w_greedy_next = sat20(g_diff);
                state_next    = S_MODEST;
            end

            S_MODEST:
            begin
                w_modest_next = sat20(m_diff);
                state_next    = S_OUT;
            end

            S_OUT:
            begin
                // Hold here until the result register is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration register writes
    always_comb
    begin
        noise_next   = noise_reg;
        band_lo_next = band_lo_reg;
        band_hi_next = band_hi_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NOISE:   noise_next   = cfg_data[9:0];
                REG_BAND_LO: band_lo_next = cfg_data;
                REG_BAND_HI: band_hi_next = cfg_data;
                default:     noise_next   = noise_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ring_idx_reg  <= '0;
            ring_vld_reg  <= '0;
            pv_sum_reg    <= '0;
            chg_sum_reg   <= '0;
            last_pv_reg   <= '0;
            last_net_reg  <= '0;
            neg_hist_reg  <= '0;
            pos_hist_reg  <= '0;
            out_valid_reg <= 1'b0;
            noise_reg     <= 10'd50;
            band_lo_reg   <= -14'sd100;
            band_hi_reg   <= 14'sd100;
        end
        else
        begin
            state_reg     <= state_next;
            ring_idx_reg  <= ring_idx_next;
            ring_vld_reg  <= ring_vld_next;
            pv_sum_reg    <= pv_sum_next;
            chg_sum_reg   <= chg_sum_next;
            last_pv_reg   <= last_pv_next;
            last_net_reg  <= last_net_next;
            neg_hist_reg  <= neg_hist_next;
            pos_hist_reg  <= pos_hist_next;
            out_valid_reg <= out_valid_next;
            noise_reg     <= noise_next;
            band_lo_reg   <= band_lo_next;
            band_hi_reg   <= band_hi_next;
        end
    end

    // Payload: capture the sample, advance the work registers, load results.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            grid_reg <= grid_power;
            batt_reg <= battery_power;
            load_reg <= site_load;
            pvm_reg  <= pv_main;
            pvs_reg  <= pv_second;
        end
        w_pv_reg       <= w_pv_next;
        w_dpv_reg      <= w_dpv_next;
        w_net_reg      <= w_net_next;
        w_dload_reg    <= w_dload_next;
        w_sum_reg      <= w_sum_next;
        w_surplus_reg  <= w_surplus_next;
        w_waste_reg    <= w_waste_next;
        w_abs_batt_reg <= w_abs_batt_next;
        w_trend_reg    <= w_trend_next;
        w_tol_reg      <= w_tol_next;
        w_dist_reg     <= w_dist_next;
        w_kf_reg       <= w_kf_next;
        w_kt_reg       <= w_kt_next;
        w_greedy_reg   <= w_greedy_next;
        w_modest_reg   <= w_modest_next;
        if ((state_reg == S_OUT) && out_free)
        begin
            o_pv_reg      <= w_pv_reg;
            o_dpv_reg     <= w_dpv_reg;
            o_net_reg     <= w_net_reg;
            o_dload_reg   <= w_dload_reg;
            o_sum_reg     <= w_sum_reg;
            o_waste_reg   <= w_waste_reg;
            o_dist_reg    <= w_dist_reg;
            o_trend_reg   <= w_trend_reg;
            o_surplus_reg <= w_surplus_reg;
            o_greedy_reg  <= w_greedy_reg;
            o_modest_reg  <= w_modest_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pv_total     = o_pv_reg;
    assign pv_change    = o_dpv_reg;
    assign net_load     = o_net_reg;
    assign load_change  = o_dload_reg;
    assign balance_sum  = o_sum_reg;
    assign waste_power  = o_waste_reg;
    assign distortion   = o_dist_reg;
    assign trend        = o_trend_reg;
    assign surplus      = o_surplus_reg;
    assign greedy_power = o_greedy_reg;
    assign modest_power = o_modest_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `PVSA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `PVSA_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy)
    `PVSA_ASSERT_NEXT(a_ring_step, state_reg == S_CALC2, ring_idx_reg == HIST_W'($past(ring_idx_reg) + 1'b1))
    `PVSA_ASSERT_NEXT(a_out_hold, (state_reg == S_OUT) && out_valid_reg && !out_ready, state_reg == S_OUT)

endmodule

`default_nettype wire
